/* src/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int ENTRIES_DEFAULT = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	localparam logic signed [31:0] MISS_VALUE = -32'sd1;
	localparam logic signed [31:0] PUT_VALUE = 32'sd0;

	typedef struct packed {
		logic               op;
		logic        [31:0] lookup_key;
		logic signed [31:0] write_value;
	} cmd_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
	} rsp_t;

	// What the back end does with one classified command.
	typedef enum logic [2:0] {
		K_GET_HIT,
		K_GET_MISS,
		K_PUT_HIT,
		K_INSERT,
		K_REPLACE,
		K_DROP
	} kind_t;

endpackage

/* src/lru_key_value_cache_core.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: present cmd (op, lookup_key, write_value) with start
//   high; the beat is taken at a rising edge where busy is low. op selects
//   get (lookup) or put (insert or update).
//   Result channel: done pulses for one cycle with rsp (hit, read_value).
//   The receiver cannot hold results off; every result is taken in the cycle
//   it is shown.
//   Configuration: cfg_we writes cfg_wdata into the capacity register; write
//   only while no command is in flight.
// Timing:
//   A new command is taken only once the last one has entered the queue:
//   the front end compares the key against all entries in the cycle after
//   acceptance, and the back end applies the table update in the cycle
//   after that, which the next compare must see.
// Reset:
//   arst_n clears all valid bits, the fill count and the pipeline; capacity
//   returns to its reset value. Keys, ranks and values need no clearing,
//   since only valid entries are ever read.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
	parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  lkvc_pkg::cmd_t             cmd,
	output logic                       busy,
	output logic                       done,
	output lkvc_pkg::rsp_t             rsp,
	input  logic                       cfg_we,
	input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata
);

	localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);

	// One classified command as it travels from front to back.
	typedef struct packed {
		lkvc_pkg::kind_t    kind;
		logic [SLOT_W-1:0]  slot;
		logic [CNT_W-1:0]   old_rank;
		logic [31:0]        key;
		logic signed [31:0] value;
	} item_t;

	// Table view the back end exposes to the front end's compare.
	logic [ENTRIES-1:0] valid;
	logic [31:0]        keys  [ENTRIES];
	logic [SLOT_W-1:0]  ranks [ENTRIES];
	logic [CNT_W-1:0]   used_count;

	logic  push;
	item_t push_item;
	logic  pop;
	item_t head;
	logic  q_empty;
	logic  q_full;

	// Front: hold the command, match, classify, push one beat into the queue.
	lkvc_front #(
		.ENTRIES (ENTRIES),
		.item_t  (item_t)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.busy       (busy),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.valid      (valid),
		.keys       (keys),
		.ranks      (ranks),
		.used_count (used_count),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	// Queue: decouple classification from execution.
	lkvc_fifo #(
		.item_t (item_t),
		.DEPTH  (lkvc_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	// Back: advance ranks, write keys and values, drive the result strobe.
	lkvc_back #(
		.ENTRIES (ENTRIES),
		.item_t  (item_t)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.head       (head),
		.pop        (pop),
		.valid      (valid),
		.keys       (keys),
		.ranks      (ranks),
		.used_count (used_count),
		.done       (done),
		.rsp        (rsp)
	);

endmodule

/* src/lkvc_ram.sv */
// ----------------------------------------------------------------------------
// lkvc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lkvc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = lkvc_pkg::ENTRIES_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/lkvc_fifo.sv */
// ----------------------------------------------------------------------------
// lkvc_fifo
// Short queue between front and back end.
// ----------------------------------------------------------------------------
module lkvc_fifo #(
	parameter type item_t = logic,
	parameter int  DEPTH  = lkvc_pkg::QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  empty,
	output logic  full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign head  = slot_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* src/lkvc_front.sv */
// ----------------------------------------------------------------------------
// lkvc_front
// Accept commands, match keys against all entries and classify each command.
// ----------------------------------------------------------------------------
module lkvc_front #(
	parameter int  ENTRIES = lkvc_pkg::ENTRIES_DEFAULT,
	parameter type item_t  = logic
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	input  lkvc_pkg::cmd_t                            cmd,
	output logic                                      busy,
	input  logic                                      cfg_we,
	input  logic [lkvc_pkg::CAP_W-1:0]                cfg_wdata,
	input  logic [ENTRIES-1:0]                        valid,
	input  logic [31:0]                               keys [ENTRIES],
	input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] ranks [ENTRIES],
	input  logic [$clog2(ENTRIES + 1)-1:0]            used_count,
	input  logic                                      q_full,
	output logic                                      push,
	output item_t                                     push_item
);

	localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

	logic                         v_s1;
	lkvc_pkg::cmd_t               cmd_s1;
	logic [lkvc_pkg::CAP_W-1:0]   capacity_q;

	logic [ENTRIES-1:0]  match;
	logic [SLOT_W-1:0]   hit_slot;
	logic [SLOT_W-1:0]   hit_rank;
	logic [SLOT_W-1:0]   lru_slot;
	logic [CNT_W-1:0]    used_m1;
	logic [CMP_W-1:0]    cap_eff;
	logic [CMP_W-1:0]    used_ext;

	assign busy = v_s1;
	assign push = v_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			capacity_q <= lkvc_pkg::CAP_RESET;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (start && !v_s1) begin
				v_s1 <= 1'b1;
			end else if (push) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !v_s1) begin
			cmd_s1 <= cmd;
		end
	end

	// Keys are unique among valid entries, so at most one bit of the match
	// vector is set and an OR of the matching indexes and ranks picks out the entry.
	always_comb begin
		match    = '0;
		hit_slot = '0;
		hit_rank = '0;
		lru_slot = '0;
		used_m1  = used_count - CNT_W'(1);
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid[i] && (keys[i] == cmd_s1.lookup_key);
			if (match[i]) begin
				hit_slot = hit_slot | SLOT_W'(i);
				hit_rank = hit_rank | ranks[i];
			end
			if (valid[i] && (CNT_W'(ranks[i]) == used_m1)) begin
				lru_slot = lru_slot | SLOT_W'(i);
			end
		end
	end

	always_comb begin
		cap_eff  = (CMP_W'(capacity_q) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES)
		                                                   : CMP_W'(capacity_q);
		used_ext = CMP_W'(used_count);

		push_item.key      = cmd_s1.lookup_key;
		push_item.value    = cmd_s1.write_value;
		push_item.slot     = hit_slot;
		push_item.old_rank = CNT_W'(hit_rank);
		if (|match) begin
			push_item.kind = (cmd_s1.op == lkvc_pkg::OP_PUT) ? lkvc_pkg::K_PUT_HIT
			                                                : lkvc_pkg::K_GET_HIT;
		end else if (cmd_s1.op == lkvc_pkg::OP_GET) begin
			push_item.kind = lkvc_pkg::K_GET_MISS;
		end else if (cap_eff == '0) begin
			push_item.kind = lkvc_pkg::K_DROP;
		end else if (used_ext < cap_eff) begin
			// Slots fill in order and are never freed, so the lowest free one
			// is the one at the fill count. All valid ranks age.
			push_item.kind     = lkvc_pkg::K_INSERT;
			push_item.slot     = used_count[SLOT_W-1:0];
			push_item.old_rank = used_count;
		end else begin
			push_item.kind     = lkvc_pkg::K_REPLACE;
			push_item.slot     = lru_slot;
			push_item.old_rank = used_m1;
		end
	end

endmodule

/* src/lkvc_back.sv */
// ----------------------------------------------------------------------------
// lkvc_back
// Carry out classified commands: update keys, ranks and values, emit results.
// ----------------------------------------------------------------------------
module lkvc_back #(
	parameter int  ENTRIES = lkvc_pkg::ENTRIES_DEFAULT,
	parameter type item_t  = logic
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      q_empty,
	input  item_t                                     head,
	output logic                                      pop,
	output logic [ENTRIES-1:0]                        valid,
	output logic [31:0]                               keys [ENTRIES],
	output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] ranks [ENTRIES],
	output logic [$clog2(ENTRIES + 1)-1:0]            used_count,
	output logic                                      done,
	output lkvc_pkg::rsp_t                            rsp
);

	localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);

	logic [ENTRIES-1:0] valid_q;
	logic [31:0]        keys_q  [ENTRIES];
	logic [SLOT_W-1:0]  ranks_q [ENTRIES];
	logic [CNT_W-1:0]   used_q;
	logic               done_q;
	logic               hit_s2;
	logic               from_ram_s2;
	logic signed [31:0] fixed_s2;

	logic        promote;
	logic        ram_we;
	logic        ram_re;
	logic [31:0] ram_rdata;

	assign pop        = !q_empty;
	assign valid      = valid_q;
	assign keys       = keys_q;
	assign ranks      = ranks_q;
	assign used_count = used_q;
	assign done       = done_q;

	always_comb begin
		promote = 1'b0;
		ram_we  = 1'b0;
		ram_re  = 1'b0;
		case (head.kind)
			lkvc_pkg::K_GET_HIT: begin
				promote = 1'b1;
				ram_re  = 1'b1;
			end
			lkvc_pkg::K_PUT_HIT,
			lkvc_pkg::K_INSERT,
			lkvc_pkg::K_REPLACE: begin
				promote = 1'b1;
				ram_we  = 1'b1;
			end
			default: begin
				promote = 1'b0;
			end
		endcase
		promote = promote && pop;
		ram_we  = ram_we && pop;
		ram_re  = ram_re && pop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= pop;
			if (pop && (head.kind == lkvc_pkg::K_INSERT)) begin
				valid_q[head.slot] <= 1'b1;
				used_q             <= used_q + CNT_W'(1);
			end
		end
	end

	// Age every valid entry more recent than the promoted one.
	always_ff @(posedge clk) begin
		if (promote) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (SLOT_W'(i) == head.slot) begin
					ranks_q[i] <= '0;
				end else if (valid_q[i] && (CNT_W'(ranks_q[i]) < head.old_rank)) begin
					ranks_q[i] <= ranks_q[i] + SLOT_W'(1);
				end
			end
		end
		if (pop && ((head.kind == lkvc_pkg::K_INSERT) ||
		            (head.kind == lkvc_pkg::K_REPLACE))) begin
			keys_q[head.slot] <= head.key;
		end
		if (pop) begin
			hit_s2      <= (head.kind == lkvc_pkg::K_GET_HIT) ||
			               (head.kind == lkvc_pkg::K_PUT_HIT);
			from_ram_s2 <= (head.kind == lkvc_pkg::K_GET_HIT);
			fixed_s2    <= (head.kind == lkvc_pkg::K_GET_MISS) ? lkvc_pkg::MISS_VALUE
			                                                   : lkvc_pkg::PUT_VALUE;
		end
	end

	lkvc_ram #(
		.WIDTH (32),
		.DEPTH (ENTRIES)
	) u_values (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head.slot),
		.wdata (head.value),
		.re    (ram_re),
		.raddr (head.slot),
		.rdata (ram_rdata)
	);

	assign rsp.hit        = hit_s2;
	assign rsp.read_value = from_ram_s2 ? $signed(ram_rdata) : fixed_s2;

endmodule

/* src/lkvc_checker.sv */
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks of the core's command and result timing and result values.
// ----------------------------------------------------------------------------
module lkvc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input lkvc_pkg::cmd_t cmd,
	input logic           busy,
	input logic           done,
	input lkvc_pkg::rsp_t rsp
);

	logic accept;
	assign accept = start && !busy;

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 done)
		else $error("result not delivered three cycles after accept");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy low right after an accepted beat");

	a_single_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe high in two consecutive cycles");

	a_get_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.hit && ($past(cmd.op, 3) == lkvc_pkg::OP_GET))
		|-> (rsp.read_value == lkvc_pkg::MISS_VALUE))
		else $error("get miss did not return minus one");

	a_put_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(cmd.op, 3) == lkvc_pkg::OP_PUT))
		|-> (rsp.read_value == lkvc_pkg::PUT_VALUE))
		else $error("put returned a nonzero value");

endmodule

bind lru_key_value_cache_core lkvc_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.cmd    (cmd),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
